/* design/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared widths, types and the arctangent constants of the polar converter.
// ----------------------------------------------------------------------------
package rtp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CORDIC_STEPS = 42;
    localparam int ANG_FRAC     = 60;

    // cordic x/y start at |re|, |im| scaled up to 40 integer-free bits
    localparam int PRE_SHIFT = 40 - SAMPLE_WIDTH;
    localparam int OUT_SHIFT = 61 - SAMPLE_WIDTH;

    localparam int XW      = 43;
    localparam int ZW      = 64;
    localparam int PH_W    = SAMPLE_WIDTH + 2;
    localparam int SQ_W    = 2 * SAMPLE_WIDTH;
    localparam int RW      = 2 * SAMPLE_WIDTH + 1;
    localparam int SHIFT_W = $clog2(CORDIC_STEPS);

    // magnitude path is shorter than the phase path; this many taps line them up
    localparam int MAG_DELAY = CORDIC_STEPS - SAMPLE_WIDTH;

    localparam int IN_DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * SAMPLE_WIDTH + 2 + 7) / 8) * 8;

    localparam logic [63:0] ONE_FIX = 64'd1 << ANG_FRAC;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 re_neg;
        logic                 im_neg;
        logic                 is_zero;
        logic                 last;
    } t_cordic;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [PH_W-1:0]  phase;
        logic [SAMPLE_WIDTH-1:0] mag;
        logic                    last;
    } t_result;

    // shift-subtract long division, only used to build the constants below
    function automatic logic [63:0] f_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          b;
        r = '0;
        q = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // pi/4 from machin's formula, series terms truncated as fixed point
    function automatic logic signed [ZW-1:0] f_quarter_pi();
        logic [63:0]          p;
        logic [63:0]          odd;
        logic signed [ZW-1:0] s5;
        logic signed [ZW-1:0] s239;
        logic signed [ZW-1:0] t;
        int                   k;
        s5   = '0;
        s239 = '0;
        p    = f_udiv(ONE_FIX, 64'd5);
        for (k = 0; k < 32; k++) begin
            if (p != 64'd0) begin
                odd = 64'(2 * k + 1);
                t   = signed'(f_udiv(p, odd));
                s5  = k[0] ? (s5 - t) : (s5 + t);
                p   = f_udiv(p, 64'd25);
            end
        end
        p = f_udiv(ONE_FIX, 64'd239);
        for (k = 0; k < 32; k++) begin
            if (p != 64'd0) begin
                odd  = 64'(2 * k + 1);
                t    = signed'(f_udiv(p, odd));
                s239 = k[0] ? (s239 - t) : (s239 + t);
                p    = f_udiv(p, 64'd57121);
            end
        end
        return (64'sd4 * s5) - s239;
    endfunction

    // atan(2^-i) as a truncated series, i >= 1
    function automatic logic signed [ZW-1:0] f_atan_pow2(input int i);
        logic [63:0]          odd;
        logic signed [ZW-1:0] sum;
        logic signed [ZW-1:0] t;
        int                   sh;
        int                   k;
        sum = '0;
        sh  = i;
        for (k = 0; k < 64; k++) begin
            if (sh <= ANG_FRAC) begin
                odd = 64'(2 * k + 1);
                t   = signed'(f_udiv(ONE_FIX >> sh, odd));
                sum = k[0] ? (sum - t) : (sum + t);
                sh  = sh + 2 * i;
            end
        end
        return sum;
    endfunction

    localparam logic signed [ZW-1:0] QUARTER_PI = f_quarter_pi();
    localparam logic signed [ZW-1:0] PI_FIX     = 64'sd4 * QUARTER_PI;
    localparam logic signed [ZW-1:0] HALF_LSB   = 64'sd1 <<< (OUT_SHIFT - 1);

    // pi in output lsbs, the largest phase a result can show
    localparam logic signed [PH_W-1:0] PH_PI = PH_W'((PI_FIX + HALF_LSB) >>> OUT_SHIFT);

    function automatic logic signed [ZW-1:0] f_atan_step(input int i);
        return (i == 0) ? QUARTER_PI : f_atan_pow2(i);
    endfunction

endpackage

/* design/rtp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rtp_cordic_cell
// One vectoring rotation: drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module rtp_cordic_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  rtp_pkg::t_cordic                     i_data,
    input  logic [rtp_pkg::SHIFT_W-1:0]          i_shift,
    input  logic signed [rtp_pkg::ZW-1:0]        i_angle,
    output logic                                 o_valid,
    output rtp_pkg::t_cordic                     o_data
);

    logic signed [rtp_pkg::XW-1:0] w_x;
    logic signed [rtp_pkg::XW-1:0] w_y;
    logic signed [rtp_pkg::XW-1:0] w_dx;
    logic signed [rtp_pkg::XW-1:0] w_dy;
    rtp_pkg::t_cordic              n_data;
    rtp_pkg::t_cordic              r_data;
    logic                          r_valid;

    assign w_x  = i_data.x;
    assign w_y  = i_data.y;
    assign w_dx = w_y >>> i_shift;
    assign w_dy = w_x >>> i_shift;

    always_comb begin
        n_data = i_data;
        if (!w_y[rtp_pkg::XW-1]) begin
            n_data.x = w_x + w_dx;
            n_data.y = w_y - w_dy;
            n_data.z = i_data.z + i_angle;
        end else begin
            n_data.x = w_x - w_dx;
            n_data.y = w_y + w_dy;
            n_data.z = i_data.z - i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* design/rtp_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rtp_sqrt_cell
// One digit of the restoring square root: trial subtract and shift of the root.
// ----------------------------------------------------------------------------
module rtp_sqrt_cell (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  rtp_pkg::t_sqrt            i_data,
    input  logic [rtp_pkg::RW-1:0]    i_bit,
    output rtp_pkg::t_sqrt            o_data
);

    logic [rtp_pkg::RW-1:0] w_trial;
    rtp_pkg::t_sqrt         n_data;
    rtp_pkg::t_sqrt         r_data;

    assign w_trial = i_data.root + i_bit;

    always_comb begin
        if (i_data.rem >= w_trial) begin
            n_data.rem  = i_data.rem - w_trial;
            n_data.root = (i_data.root >> 1) + i_bit;
        end else begin
            n_data.rem  = i_data.rem;
            n_data.root = i_data.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

/* design/rectangular_to_polar.sv */
// ----------------------------------------------------------------------------
// rectangular_to_polar
// Streams complex bins to magnitude and phase through a row of cordic cells,
// with a digit-serial square root row running alongside.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                 | tlast
//  s_axis   | in        | real_part[15:0], imag_part[15:0]   | last_bin
//  m_axis   | out       | magnitude[15:0], phase_angle[17:0] | last_out
//
//  one item per clock while the output is not stalled; a result passes through
//  the entry stage, the 42 cordic cells, two angle-fixup stages and the
//  output register before it shows on m_axis.
//  reset (i_rst_n low, synchronous) clears all valid bits, output and skid.
//  a stalled output parks one more result in the skid register; s_axis_tready
//  drops only while that register is full, and the whole row holds then.
// ----------------------------------------------------------------------------
module rectangular_to_polar (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // real_part, imag_part
    input  logic [rtp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // magnitude, phase_angle, zero pad
    output logic [rtp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int SW = rtp_pkg::SAMPLE_WIDTH;
    localparam int NC = rtp_pkg::CORDIC_STEPS;
    localparam int ND = rtp_pkg::MAG_DELAY;

    logic                         w_en;
    logic [SW-1:0]                w_re;
    logic [SW-1:0]                w_im;
    logic [SW-1:0]                w_ar;
    logic [SW-1:0]                w_ai;

    logic                         r_s0_valid;
    logic [SW-1:0]                r_s0_ar;
    logic [SW-1:0]                r_s0_ai;
    logic                         r_s0_re_neg;
    logic                         r_s0_im_neg;
    logic                         r_s0_zero;
    logic                         r_s0_last;

    rtp_pkg::t_cordic             w_cd [NC+1];
    logic [NC:0]                  w_cv;

    logic                         r_p1_valid;
    logic signed [rtp_pkg::ZW-1:0] r_p1_z;
    logic                         r_p1_im_neg;
    logic                         r_p1_zero;
    logic                         r_p1_last;
    logic signed [rtp_pkg::ZW-1:0] w_sum;

    logic                         r_p2_valid;
    logic signed [rtp_pkg::PH_W-1:0] r_p2_phase;
    logic                         r_p2_last;

    logic [rtp_pkg::SQ_W-1:0]     r_sq_re;
    logic [rtp_pkg::SQ_W-1:0]     r_sq_im;
    logic [rtp_pkg::RW-1:0]       r_rad;
    rtp_pkg::t_sqrt               w_sq [SW+1];
    logic [rtp_pkg::RW-1:0]       w_root_rnd;
    logic [SW-1:0]                r_mag_dly [ND];

    rtp_pkg::t_result             w_new;
    rtp_pkg::t_result             r_out;
    rtp_pkg::t_result             r_skid;
    logic                         r_out_valid;
    logic                         r_skid_valid;

    // the row moves whenever the skid register is free
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    assign w_re = s_axis_tdata[SW-1:0];
    assign w_im = s_axis_tdata[2*SW-1:SW];
    assign w_ar = w_re[SW-1] ? (~w_re + 1'b1) : w_re;
    assign w_ai = w_im[SW-1] ? (~w_im + 1'b1) : w_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= s_axis_tvalid;
            r_p1_valid <= w_cv[NC];
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_ar     <= w_ar;
            r_s0_ai     <= w_ai;
            r_s0_re_neg <= w_re[SW-1];
            r_s0_im_neg <= w_im[SW-1];
            r_s0_zero   <= (w_re == '0) && (w_im == '0);
            r_s0_last   <= s_axis_tlast;
        end
    end

    // cordic row
    always_comb begin
        w_cd[0].x       = {{(rtp_pkg::XW-SW){1'b0}}, r_s0_ar} << rtp_pkg::PRE_SHIFT;
        w_cd[0].y       = {{(rtp_pkg::XW-SW){1'b0}}, r_s0_ai} << rtp_pkg::PRE_SHIFT;
        w_cd[0].z       = '0;
        w_cd[0].re_neg  = r_s0_re_neg;
        w_cd[0].im_neg  = r_s0_im_neg;
        w_cd[0].is_zero = r_s0_zero;
        w_cd[0].last    = r_s0_last;
    end
    assign w_cv[0] = r_s0_valid;

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        localparam logic signed [rtp_pkg::ZW-1:0] ANGLE = rtp_pkg::f_atan_step(g);
        rtp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_data  (w_cd[g]),
            .i_shift (rtp_pkg::SHIFT_W'(g)),
            .i_angle (ANGLE),
            .o_valid (w_cv[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    // fold the first-quadrant angle back to the input's quadrant
    assign w_sum = r_p1_im_neg ? (rtp_pkg::HALF_LSB - r_p1_z) : (r_p1_z + rtp_pkg::HALF_LSB);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_z      <= w_cd[NC].re_neg ? (rtp_pkg::PI_FIX - w_cd[NC].z) : w_cd[NC].z;
            r_p1_im_neg <= w_cd[NC].im_neg;
            r_p1_zero   <= w_cd[NC].is_zero;
            r_p1_last   <= w_cd[NC].last;
            r_p2_phase  <= r_p1_zero ? '0 :
                           w_sum[rtp_pkg::OUT_SHIFT+rtp_pkg::PH_W-1:rtp_pkg::OUT_SHIFT];
            r_p2_last   <= r_p1_last;
        end
    end

    // square root row
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_re <= rtp_pkg::SQ_W'(r_s0_ar) * rtp_pkg::SQ_W'(r_s0_ar);
            r_sq_im <= rtp_pkg::SQ_W'(r_s0_ai) * rtp_pkg::SQ_W'(r_s0_ai);
            r_rad   <= rtp_pkg::RW'(r_sq_re) + rtp_pkg::RW'(r_sq_im);
        end
    end

    assign w_sq[0].rem  = r_rad;
    assign w_sq[0].root = '0;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        localparam logic [rtp_pkg::RW-1:0] BIT_K = rtp_pkg::RW'(1) << (2 * (SW - 1 - k));
        rtp_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_data (w_sq[k]),
            .i_bit  (BIT_K),
            .o_data (w_sq[k+1])
        );
    end

    // round to nearest: a remainder above the root means the upper neighbor
    assign w_root_rnd = (w_sq[SW].rem > w_sq[SW].root) ? (w_sq[SW].root + 1'b1) : w_sq[SW].root;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_dly[0] <= w_root_rnd[SW-1:0];
            for (int j = 1; j < ND; j++) begin
                r_mag_dly[j] <= r_mag_dly[j-1];
            end
        end
    end

    // output register with one skid entry
    assign w_new.phase = r_p2_phase;
    assign w_new.mag   = r_mag_dly[ND-1];
    assign w_new.last  = r_p2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_p2_valid;
        end else if (r_p2_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || m_axis_tready) begin
            r_out <= w_new;
        end else begin
            r_skid <= w_new;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = rtp_pkg::OUT_DATA_W'({r_out.phase, r_out.mag});
    assign m_axis_tlast  = r_out.last;

endmodule

/* design/rtp_checker.sv */
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks of the polar converter, bound to its top level.
// ----------------------------------------------------------------------------
module rtp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [rtp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic                               m_axis_tlast
);

    localparam int SW = rtp_pkg::SAMPLE_WIDTH;

    logic signed [rtp_pkg::PH_W-1:0] w_ph;

    assign w_ph = m_axis_tdata[rtp_pkg::PH_W+SW-1:SW];

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // input side only backs off once the output has been stalled
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_ph <= rtp_pkg::PH_PI) && (w_ph >= -rtp_pkg::PH_PI))
        else $error("phase outside minus pi to pi");

endmodule

bind rectangular_to_polar rtp_checker u_rtp_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams complex bins into rectangular_to_polar and checks every magnitude,
// phase and last flag against a bit-exact cordic and rounded square root
// computed here. Both stream sides idle at random; the receiver holds off once
// for a long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SW         = rtp_pkg::SAMPLE_WIDTH;
    localparam int PW         = SW + 2;
    localparam int IN_W       = rtp_pkg::IN_DATA_W;
    localparam int OUT_W      = rtp_pkg::OUT_DATA_W;
    localparam int N_STEPS    = 42;
    localparam int FRAC_BITS  = 60;
    localparam int PRE_SH     = 40 - SW;
    localparam int POST_SH    = 61 - SW;
    localparam int N_RANDOM   = 1650;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 60;

    typedef struct packed {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 last;
    } bin_t;

    typedef struct packed {
        logic [SW-1:0]        mag;
        logic signed [PW-1:0] phase;
        logic                 last;
    } polar_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // real_part, imag_part
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // magnitude, phase_angle, zero pad
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;

    rectangular_to_polar i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    longint arctan_steps[N_STEPS];
    longint pi_q60;

    bin_t   bins_to_send[$];
    polar_t polar_due[$];
    bin_t   bin_on_bus;

    int n_sent;
    int n_recv;
    int n_frames;
    int n_errors;
    int idle_cycles;
    int hold_left;
    bit hold_done;

    // atan(1/n) * 2^60 by its truncated power series
    function automatic longint arctan_of_inverse(longint unsigned n);
        logic [127:0] term;
        logic [127:0] n_sq;
        longint       acc;
        int           k;
        term = (128'd1 << FRAC_BITS) / n;
        n_sq = 128'(n) * 128'(n);
        acc  = 0;
        k    = 0;
        while (term != 0) begin
            if (k % 2 == 1) begin
                acc = acc - longint'(term / (2 * k + 1));
            end else begin
                acc = acc + longint'(term / (2 * k + 1));
            end
            term = term / n_sq;
            k++;
        end
        return acc;
    endfunction

    function automatic polar_t to_polar(bin_t b);
        polar_t            res;
        longint            re_v;
        longint            im_v;
        longint            x;
        longint            y;
        longint            z;
        longint            dx;
        longint            dy;
        longint            ph;
        longint unsigned   sum_sq;
        longint unsigned   root;
        longint unsigned   trial;
        int                i;
        re_v = longint'(b.re);
        im_v = longint'(b.im);
        if (re_v < 0) re_v = -re_v;
        if (im_v < 0) im_v = -im_v;

        sum_sq = longint'(re_v * re_v + im_v * im_v);
        root   = 0;
        for (i = SW; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= sum_sq) root = trial;
        end
        // round to nearest: the remainder beats the root
        if (sum_sq - root * root > root) root = root + 1;

        if (b.re == 0 && b.im == 0) begin
            ph = 0;
        end else begin
            x = re_v <<< PRE_SH;
            y = im_v <<< PRE_SH;
            z = 0;
            for (i = 0; i < N_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_steps[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_steps[i];
                end
            end
            if (b.re < 0) z = pi_q60 - z;
            if (b.im < 0) z = -z;
            ph = (z + (64'sd1 <<< (POST_SH - 1))) >>> POST_SH;
        end
        res.mag   = root[SW-1:0];
        res.phase = ph[PW-1:0];
        res.last  = b.last;
        return res;
    endfunction

    // mostly back to back, now and then a pause, rarely a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [SW-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0:       return -(2 ** (SW - 1));
            1:       return -(2 ** (SW - 1)) + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 2 ** (SW - 1) - 1;
            default: return SW'($urandom);
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- sender ----------------
    int send_gap;
    int send_calm;

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            send_gap      = 0;
            send_calm     = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                polar_due.push_back(to_polar(bin_on_bus));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                next_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (bins_to_send.size() > 0) begin
                    bin_on_bus = bins_to_send.pop_front();
                    s_axis_tdata <= IN_W'({bin_on_bus.im, bin_on_bus.re});
                    s_axis_tlast <= bin_on_bus.last;
                    next_valid = 1'b1;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else if ($urandom_range(0, 49) == 0) begin
                        send_calm = $urandom_range(50, 150);
                    end else begin
                        send_gap = pick_idle();
                    end
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // ---------------- receiver ----------------
    int recv_stall;
    int recv_calm;

    always @(posedge i_clk) begin
        polar_t got;
        polar_t want;
        logic   rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    = 0;
            recv_calm     = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.mag   = m_axis_tdata[SW-1:0];
                got.phase = m_axis_tdata[SW+PW-1:SW];
                got.last  = m_axis_tlast;
                n_recv++;
                if (got.last) n_frames++;
                if (polar_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: mag %0d phase %0d last %0b",
                                 got.mag, got.phase, got.last);
                end else begin
                    want = polar_due.pop_front();
                    if (got.mag !== want.mag || got.phase !== want.phase
                            || got.last !== want.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d: mag %0d/%0d phase %0d/%0d last %0b/%0b (exp/got)",
                                     n_recv, want.mag, got.mag, want.phase, got.phase,
                                     want.last, got.last);
                    end
                end
            end
            rdy = 1'b1;
            if (recv_stall > 0) begin
                recv_stall--;
                rdy = 1'b0;
            end else if (recv_calm > 0) begin
                recv_calm--;
            end else if ($urandom_range(0, 59) == 0) begin
                recv_calm = $urandom_range(50, 150);
            end else if ($urandom_range(0, 2) == 0) begin
                recv_stall = pick_idle();
            end
            m_axis_tready <= rdy && (hold_left == 0);
        end
    end

    // one long hold-off on the output so the row fills and tready drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_recv >= HOLD_AFTER) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d idle cycles, %0d results still due",
                         idle_cycles, polar_due.size());
                $display("rectangular_to_polar: mismatch");
                $finish;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        bin_t b;
        int   i;
        int   kind;
        int   mg;
        i_rst_n     = 1'b0;
        n_sent      = 0;
        n_recv      = 0;
        n_frames    = 0;
        n_errors    = 0;
        idle_cycles = 0;

        arctan_steps[0] = 4 * arctan_of_inverse(5) - arctan_of_inverse(239);
        pi_q60          = 4 * arctan_steps[0];
        for (i = 1; i < N_STEPS; i++)
            arctan_steps[i] = arctan_of_inverse(64'd1 << i);

        // directed: origin, axes, negative real axis, corners, tiny values
        bins_to_send.push_back('{re: 0, im: 0, last: 1'b0});
        bins_to_send.push_back('{re: 0, im: 0, last: 1'b1});
        bins_to_send.push_back('{re: 1, im: 0, last: 1'b0});
        bins_to_send.push_back('{re: -1, im: 0, last: 1'b0});
        bins_to_send.push_back('{re: 0, im: 1, last: 1'b0});
        bins_to_send.push_back('{re: 0, im: -1, last: 1'b0});
        bins_to_send.push_back('{re: 32767, im: 0, last: 1'b0});
        bins_to_send.push_back('{re: -32768, im: 0, last: 1'b0});
        bins_to_send.push_back('{re: 0, im: 32767, last: 1'b0});
        bins_to_send.push_back('{re: 0, im: -32768, last: 1'b0});
        bins_to_send.push_back('{re: -32768, im: -32768, last: 1'b1});
        bins_to_send.push_back('{re: 32767, im: 32767, last: 1'b0});
        bins_to_send.push_back('{re: -32768, im: 32767, last: 1'b0});
        bins_to_send.push_back('{re: 32767, im: -32768, last: 1'b0});
        bins_to_send.push_back('{re: 1, im: 1, last: 1'b0});
        bins_to_send.push_back('{re: -1, im: -1, last: 1'b0});
        bins_to_send.push_back('{re: -1, im: 1, last: 1'b0});
        bins_to_send.push_back('{re: -32768, im: 1, last: 1'b0});
        bins_to_send.push_back('{re: -32768, im: -1, last: 1'b0});
        bins_to_send.push_back('{re: 3, im: 4, last: 1'b0});
        bins_to_send.push_back('{re: -21845, im: 10922, last: 1'b1});

        for (i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 99);
            b.re = SW'($urandom);
            b.im = SW'($urandom);
            if (kind < 15) begin
                b.re = SW'($urandom_range(0, 15)) - 8;
                b.im = SW'($urandom_range(0, 15)) - 8;
            end else if (kind < 30) begin
                if ($urandom_range(0, 1)) b.re = 0;
                else b.im = 0;
            end else if (kind < 40) begin
                // just around the branch cut at +-pi
                b.re = -SW'($urandom_range(1, 32768));
                b.im = SW'($urandom_range(0, 6)) - 3;
            end else if (kind < 50) begin
                mg   = $urandom_range(1, 32768);
                b.re = $urandom_range(0, 1) ? -SW'(mg) : SW'(mg);
                b.im = $urandom_range(0, 1) ? -SW'(mg) : SW'(mg);
            end else if (kind < 60) begin
                b.re = pick_extreme();
                b.im = pick_extreme();
            end
            b.last = ($urandom_range(0, 15) == 0);
            bins_to_send.push_back(b);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bins_to_send.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (polar_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d bins in %0d frames: origin, axes, +-pi cut, corners, random",
                 n_sent, n_frames);
        $display("got %0d results with random stalls and one %0d-cycle output hold-off",
                 n_recv, HOLD_LEN);
        if (n_errors == 0 && polar_due.size() == 0) begin
            $display("rectangular_to_polar: match");
        end else begin
            $display("%0d bad results, %0d still due", n_errors, polar_due.size());
            $display("rectangular_to_polar: mismatch");
        end
        $finish;
    end

endmodule
